[src/bounded_hop_reachability_defines.svh]
// Assertion macros for the bounded hop reachability block.
// No dependencies; included by the top level.
`ifndef BOUNDED_HOP_REACHABILITY_DEFINES_SVH
`define BOUNDED_HOP_REACHABILITY_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define BHR_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BHR_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/bhr_pkg.sv]
// Shared field widths and codes for the bounded hop reachability block.
// No dependencies.
package bhr_pkg;

   localparam int VERTEX_W   = 3;
   localparam int STEPS_W    = 4;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   localparam logic ACT_ADD   = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

endpackage

[src/bounded_hop_reachability.sv]
// Bounded hop reachability over a small directed graph held as an adjacency memory.
// Depends on bhr_pkg and bounded_hop_reachability_defines.svh.
//
// Usage:
//   req channel: one item is an edge add (tuser = 0) or a reachability query
//   (tuser = 1). tdata carries from_vertex, to_vertex and max_steps.
//   rsp channel: exactly one item per request. tuser = 1 marks a query answer,
//   tdata[0] gives reachable (always 0 for an add acknowledgement).
// Timing:
//   An add takes one memory read and one write: the acknowledgement passes
//   S_WRITE, then S_DONE, into the rsp register. A query walks the graph breadth
//   first, one adjacency row read per cycle from the row memory while the
//   frontier holds vertices, and a level step in S_PICK each time it empties.
//   Only one item is in flight; req_tready is high while the block is idle,
//   even when an earlier result still waits on the rsp side.
// Reset:
//   Synchronous, active high. Per-row valid flags clear at once, so the graph
//   reads as empty as soon as reset is released; no clearing pass is run.
// Stall:
//   A finished result waits in the rsp register until taken; a following
//   item is worked on meanwhile and holds its own result until the register
//   frees.
`include "bounded_hop_reachability_defines.svh"

module bounded_hop_reachability
   import bhr_pkg::*;
#(
   parameter int NODES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [2:0] from_vertex, [5:3] to_vertex, [9:6] max_steps, [15:10] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] action
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] reachable, [7:1] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] is_answer
   output logic                  rsp_tuser
);

   localparam int IDX_W = $clog2(NODES);

   typedef logic [NODES-1:0] row_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef enum logic [1:0] {S_IDLE, S_WRITE, S_PICK, S_DONE} state_type;

   function automatic idx_type onehot_to_idx(input row_type oh);
      idx_type idx;
      idx = '0;
      for (int i = 0; i < NODES; i++) begin
         if (oh[i]) begin
            idx = idx | idx_type'(i);
         end
      end
      return idx;
   endfunction

   state_type                state_ff, state_in;
   logic                     query_ff, query_in;
   logic                     range_ff, range_in;
   idx_type                  src_ff, src_in;
   idx_type                  dst_ff, dst_in;
   row_type                  vis_ff, vis_in;
   row_type                  front_ff, front_in;
   row_type                  next_ff, next_in;
   logic [STEPS_W-1:0]       remain_ff, remain_in;
   logic                     pend_ff, pend_in;
   logic                     rd_vld_ff, rd_vld_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_user_ff, rsp_user_in;
   logic                     rsp_reach_ff, rsp_reach_in;
   row_type                  row_vld_ff, row_vld_in;

   row_type                  edge_rows_ff [NODES];
   row_type                  rd_data_ff;

   logic                     rd_en;
   idx_type                  rd_addr;
   logic                     wr_en;
   row_type                  wr_data;

   logic [VERTEX_W-1:0]      req_from;
   logic [VERTEX_W-1:0]      req_to;
   logic [STEPS_W-1:0]       req_steps;
   logic [STEPS_W-1:0]       steps_eff;
   logic                     req_range;
   idx_type                  req_src_idx;
   idx_type                  req_dst_idx;
   logic                     req_fire;
   row_type                  acc_row;
   row_type                  next_full;
   row_type                  pick_oh;
   idx_type                  pick_idx;
   row_type                  new_set;

   assign req_from    = req_tdata[VERTEX_W-1:0];
   assign req_to      = req_tdata[2*VERTEX_W-1:VERTEX_W];
   assign req_steps   = req_tdata[2*VERTEX_W+STEPS_W-1:2*VERTEX_W];
   assign req_range   = (int'(req_from) < NODES) && (int'(req_to) < NODES);
   assign req_src_idx = idx_type'(req_from);
   assign req_dst_idx = idx_type'(req_to);
   assign steps_eff   = (int'(req_steps) > NODES - 1) ? STEPS_W'(NODES - 1) : req_steps;

   assign req_tready  = (state_ff == S_IDLE);
   assign req_fire    = req_tvalid && req_tready;

   assign acc_row     = (pend_ff && rd_vld_ff) ? rd_data_ff : '0;
   assign next_full   = next_ff | acc_row;
   assign pick_oh     = front_ff & (~front_ff + row_type'(1));
   assign pick_idx    = onehot_to_idx(pick_oh);
   assign new_set     = next_full & ~vis_ff;

   always_comb begin
      state_in     = state_ff;
      query_in     = query_ff;
      range_in     = range_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      vis_in       = vis_ff;
      front_in     = front_ff;
      next_in      = next_ff;
      remain_in    = remain_ff;
      pend_in      = 1'b0;
      rd_vld_in    = rd_vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_user_in  = rsp_user_ff;
      rsp_reach_in = rsp_reach_ff;
      row_vld_in   = row_vld_ff;
      rd_en        = 1'b0;
      rd_addr      = req_src_idx;
      wr_en        = 1'b0;
      wr_data      = (rd_vld_ff ? rd_data_ff : '0) | (row_type'(1) << dst_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               query_in  = (req_tuser == ACT_QUERY);
               range_in  = req_range;
               src_in    = req_src_idx;
               dst_in    = req_dst_idx;
               vis_in    = row_type'(1) << req_src_idx;
               front_in  = row_type'(1) << req_src_idx;
               next_in   = '0;
               remain_in = steps_eff;
               rd_en     = req_range;
               rd_vld_in = req_range ? row_vld_ff[req_src_idx] : 1'b0;
               if (req_tuser == ACT_ADD) begin
                  state_in = S_WRITE;
               end else if (!req_range || steps_eff == '0) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_PICK;
               end
            end
         end
         S_WRITE: begin
            wr_en = range_ff;
            if (range_ff) begin
               row_vld_in[src_ff] = 1'b1;
            end
            state_in = S_DONE;
         end
         S_PICK: begin
            next_in = next_full;
            if (front_ff != '0) begin
               rd_en     = 1'b1;
               rd_addr   = pick_idx;
               rd_vld_in = row_vld_ff[pick_idx];
               front_in  = front_ff & ~pick_oh;
               pend_in   = 1'b1;
            end else begin
               vis_in    = vis_ff | new_set;
               front_in  = new_set;
               next_in   = '0;
               remain_in = remain_ff - STEPS_W'(1);
               if (remain_ff == STEPS_W'(1) || new_set == '0) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = query_ff;
               rsp_reach_in = query_ff && range_ff && vis_ff[dst_ff];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         row_vld_ff   <= '0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         row_vld_ff   <= row_vld_in;
         pend_ff      <= pend_in;
      end
      query_ff     <= query_in;
      range_ff     <= range_in;
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      vis_ff       <= vis_in;
      front_ff     <= front_in;
      next_ff      <= next_in;
      remain_ff    <= remain_in;
      rd_vld_ff    <= rd_vld_in;
      rsp_user_ff  <= rsp_user_in;
      rsp_reach_ff <= rsp_reach_in;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= edge_rows_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         edge_rows_ff[src_ff] <= wr_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-1){1'b0}}, rsp_reach_ff};

   `BHR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, state_ff != S_IDLE,
      "block still idle after accepting an item")
   `BHR_ASSERT_NOW(a_ack_not_reachable, clock, reset, rsp_tvalid && !rsp_tuser,
      rsp_tdata[0] == 1'b0, "add acknowledgement reports reachable")
   `BHR_ASSERT_NOW(a_front_in_visited, clock, reset, state_ff == S_PICK,
      (front_ff & ~vis_ff) == '0, "frontier holds a vertex outside the visited set")

endmodule
